// ===== sv/prr_pkg.sv =====
// Shared types and constants of the polyphase rational resampler.
package prr_pkg;

  localparam int DATA_W   = 32;
  localparam int ACC_W    = 64;
  localparam int Q_SHIFT  = 30;
  localparam int COEF_AW  = 7;
  localparam int COEF_DEPTH = 1 << COEF_AW;
  localparam int UP_W     = 4;
  localparam int DOWN_W   = 5;
  localparam int TAPS_W   = 5;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int PH_W     = 6;
  localparam int PH_MIN   = -32;
  localparam int PH_MAX   = 31;
  localparam int R_W      = 8;
  localparam int MAX_OUT  = 8;
  localparam int CNT_W    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_UP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS = 2'd2;

  localparam logic KIND_COEF   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CALC  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  typedef struct packed {
    logic valid;
    logic first;
  } mac_ctl_t;

endpackage

// ===== sv/prr_feed_if.sv =====
// Input channel: coefficient loads and samples.
interface prr_feed_if;
  import prr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [COEF_AW-1:0]        coef_index;
  logic signed [DATA_W-1:0]  coef_value;
  logic signed [DATA_W-1:0]  sample_in;

  modport source (output valid, kind, coef_index, coef_value, sample_in, input ready);
  modport sink (input valid, kind, coef_index, coef_value, sample_in, output ready);
endinterface

// ===== sv/prr_result_if.sv =====
// Output channel: resampled samples.
interface prr_result_if;
  import prr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [DATA_W-1:0]  sample_out;
  logic                      last;

  modport source (output valid, sample_out, last, input ready);
  modport sink (input valid, sample_out, last, output ready);
endinterface

// ===== sv/prr_mac.sv =====
// Shared multiply-accumulate unit: registered product, wrapping 64-bit accumulator.
module prr_mac (
  input  logic                            clk,
  input  logic                            rst,
  input  prr_pkg::mac_ctl_t               ctl,
  input  logic signed [prr_pkg::DATA_W-1:0] coef,
  input  logic signed [prr_pkg::DATA_W-1:0] tap,
  output logic                            busy,
  output logic [prr_pkg::ACC_W-1:0]       acc
);
  import prr_pkg::*;

  logic signed [ACC_W-1:0] prod;
  logic                    prod_valid;
  logic                    prod_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      prod_first <= 1'b0;
    end else begin
      prod_valid <= ctl.valid;
      prod_first <= ctl.first;
    end
  end

  always_ff @(posedge clk) begin
    prod <= ACC_W'(coef) * ACC_W'(tap);
    if (prod_valid) begin
      acc <= prod_first ? prod : acc + prod;
    end
  end

  assign busy = prod_valid;

endmodule

// ===== sv/polyphase_rational_resampler_core.sv =====
// Polyphase rational resampler: sequencer, history, coefficient memory and output register.
//
// Usage: feed carries items; kind 0 writes coef_value to the coefficient word at
// coef_index, kind 1 feeds sample_in. Each sample yields zero to eight results on
// result, last set on the final one of that sample. Write up_factor (0),
// down_factor (1) and taps_per_phase (2) through cfg_wr_en/cfg_index/cfg_data
// while idle; every coefficient word a phase reads must be loaded first.
// Sequencing: a coefficient load leaves the block idle, ready for the next item.
// The results of a sample are computed in turn: one multiplier serves all
// products, one tap per cycle, and each sum then drains through the memory read,
// the product register and the accumulator. feed.ready is low until all results
// of that sample are emitted and the sequencer is back in idle.
// If result stalls, the finished value waits in the output register and the
// sequencer holds before the next emit; a new item is still taken once the
// last result of a sample sits in that register.
// Reset clears the history to zero, the phase to zero and the factors to
// 1, 1 and 16. The coefficient memory is not cleared.
module polyphase_rational_resampler_core #(
  parameter int MAX_TAPS = 16,
  parameter int MAX_UP   = 8,
  parameter int MAX_DOWN = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  prr_feed_if.sink                         feed,
  prr_result_if.source                     result,
  input  logic                             cfg_wr_en,
  input  logic [prr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [prr_pkg::CFG_W-1:0]        cfg_data
);
  import prr_pkg::*;

  localparam int LW = $clog2(MAX_UP + 1);
  localparam int DW = $clog2(MAX_DOWN + 1);
  localparam int TW = $clog2(MAX_TAPS + 1);
  localparam int HW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam logic [HW-1:0] HIDX_LAST = HW'(MAX_TAPS - 1);

  logic [UP_W-1:0]   up_factor;
  logic [DOWN_W-1:0] down_factor;
  logic [TAPS_W-1:0] taps_per_phase;

  logic [LW-1:0] l_eff;
  logic [DW-1:0] m_eff;
  logic [TW-1:0] t_eff;
  logic signed [R_W-1:0] l_ext, m_ext, r_plus, r_fin;
  logic signed [PH_W-1:0] ph_next;
  logic [HW-1:0] hist_start;

  state_t state;
  logic signed [PH_W-1:0] phase_offset;
  logic signed [R_W-1:0]  r;
  logic [CNT_W-1:0]       cnt;
  logic                   v1;
  mac_ctl_t               mac_ctl;
  logic                   mac_busy;
  logic [ACC_W-1:0]       mac_acc;

  logic signed [DATA_W-1:0] sample_reg;
  logic [COEF_AW-1:0]       addr;
  logic [HW-1:0]            hidx;
  logic signed [DATA_W-1:0] coef_rd, tap_rd;
  logic signed [DATA_W-1:0] history [MAX_TAPS];
  logic signed [DATA_W-1:0] coef_mem [COEF_DEPTH];

  logic feed_fire, sample_fire, coef_fire, emit_fire, last_now;

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      up_factor      <= UP_W'(1);
      down_factor    <= DOWN_W'(1);
      taps_per_phase <= TAPS_W'(16);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_UP:   up_factor      <= cfg_data[UP_W-1:0];
        REG_DOWN: down_factor    <= cfg_data[DOWN_W-1:0];
        REG_TAPS: taps_per_phase <= cfg_data[TAPS_W-1:0];
        default: ;
      endcase
    end
  end

  assign l_eff = (up_factor == '0) ? LW'(1) :
                 (int'(up_factor) > MAX_UP) ? LW'(MAX_UP) : LW'(up_factor);
  assign m_eff = (down_factor == '0) ? DW'(1) :
                 (int'(down_factor) > MAX_DOWN) ? DW'(MAX_DOWN) : DW'(down_factor);
  assign t_eff = (taps_per_phase == '0) ? TW'(1) :
                 (int'(taps_per_phase) > MAX_TAPS) ? TW'(MAX_TAPS) : TW'(taps_per_phase);

  assign l_ext      = signed'(R_W'(l_eff));
  assign m_ext      = signed'(R_W'(m_eff));
  assign hist_start = HW'(MAX_TAPS - int'(t_eff));
  assign r_plus     = r + m_ext;
  assign r_fin      = r - l_ext;
  assign ph_next    = (r_fin < PH_MIN) ? PH_W'(PH_MIN) :
                      (r_fin > PH_MAX) ? PH_W'(PH_MAX) : PH_W'(r_fin);

  assign feed.ready  = (state == S_IDLE);
  assign feed_fire   = feed.valid && feed.ready;
  assign sample_fire = feed_fire && (feed.kind == KIND_SAMPLE);
  assign coef_fire   = feed_fire && (feed.kind == KIND_COEF);
  assign last_now    = (r_plus > 0) || (cnt == CNT_W'(MAX_OUT - 1));
  assign emit_fire   = (state == S_DRAIN) && !v1 && !mac_busy &&
                       (!result.valid || result.ready);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase_offset  <= '0;
      r             <= '0;
      cnt           <= '0;
      v1            <= 1'b0;
      mac_ctl       <= '0;
      result.valid  <= 1'b0;
    end else begin
      v1            <= (state == S_CALC);
      mac_ctl.valid <= (state == S_CALC);
      mac_ctl.first <= (state == S_CALC) && (hidx == hist_start);
      if (emit_fire) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample_fire) begin
            r   <= R_W'(phase_offset);
            cnt <= '0;
            state <= (phase_offset <= 0) ? S_CALC : S_FIN;
          end
        end
        S_CALC: begin
          if (hidx == HIDX_LAST) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (emit_fire) begin
            r     <= r_plus;
            cnt   <= cnt + CNT_W'(1);
            state <= last_now ? S_FIN : S_CALC;
          end
        end
        S_FIN: begin
          phase_offset <= ph_next;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Address counters, operand fetch and output payload
  always_ff @(posedge clk) begin
    if (sample_fire) begin
      sample_reg <= feed.sample_in;
      addr       <= COEF_AW'(-R_W'(phase_offset));
      hidx       <= hist_start;
    end else if (state == S_CALC) begin
      addr <= addr + COEF_AW'(l_eff);
      hidx <= hidx + HW'(1);
    end else if (emit_fire) begin
      addr <= COEF_AW'(-r_plus);
      hidx <= hist_start;
    end
    tap_rd <= history[hidx];
    if (emit_fire) begin
      result.sample_out <= mac_acc[Q_SHIFT+DATA_W-1:Q_SHIFT];
      result.last       <= last_now;
    end
  end

  always_ff @(posedge clk) begin
    if (coef_fire) begin
      coef_mem[feed.coef_index] <= feed.coef_value;
    end
    coef_rd <= coef_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TAPS; i++) history[i] <= '0;
    end else if (state == S_FIN) begin
      for (int i = 0; i < MAX_TAPS - 1; i++) history[i] <= history[i+1];
      history[MAX_TAPS-1] <= sample_reg;
    end
  end

  prr_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .coef (coef_rd),
    .tap  (tap_rd),
    .busy (mac_busy),
    .acc  (mac_acc)
  );

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!v1 && !mac_busy && !mac_ctl.valid))
    else $error("MAC pipeline busy while idle");

  a_calc_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CALC) |-> (hidx >= hist_start))
    else $error("history index below window");

  a_emit_next: assert property (@(posedge clk) disable iff (rst)
    (emit_fire && !last_now) |=> (state == S_CALC) && (hidx == hist_start))
    else $error("next output not started after emit");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state == S_DRAIN))
    else $error("result raised outside drain");

endmodule

// ===== dv/prr_output_checker.sv =====
`timescale 1ns / 1ps
// Resampler checker: predicts each output from the requests it sees and compares.
module prr_output_checker (
  input  logic                          clk,
  input  logic                          rst,
  prr_feed_if                           feed,
  prr_result_if                         result,
  input  logic                          cfg_wr_en,
  input  logic [prr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prr_pkg::CFG_W-1:0]     cfg_data,
  output int                            fail_count,
  output int                            outstanding
);
  import prr_pkg::*;

  localparam int HIST_LEN = 16;
  localparam int UP_LIM   = 8;
  localparam int DOWN_LIM = 16;

  typedef struct {
    logic signed [DATA_W-1:0] sample_out;
    logic                     last;
  } out_item_t;

  out_item_t                due_outputs[$];
  logic signed [DATA_W-1:0] hist [HIST_LEN];
  logic signed [DATA_W-1:0] coef_mem [COEF_DEPTH];
  logic [UP_W-1:0]          up_reg;
  logic [DOWN_W-1:0]        down_reg;
  logic [TAPS_W-1:0]        taps_reg;
  int                       phase_off;

  initial fail_count = 0;

  function automatic int clip(int v, int hi);
    return (v < 1) ? 1 : (v > hi) ? hi : v;
  endfunction

  // Dot product of one polyphase branch with the newest nt history samples.
  function automatic logic signed [DATA_W-1:0] fir_point(int ph, int nl, int nt);
    longint             acc;
    logic [COEF_AW-1:0] addr;
    int                 j;
    acc = 0;
    for (j = 0; j < nt; j++) begin
      addr = COEF_AW'(j * nl + ph);
      acc += longint'(coef_mem[addr]) * longint'(hist[HIST_LEN - nt + j]);
    end
    acc = acc >>> Q_SHIFT;
    return acc[DATA_W-1:0];
  endfunction

  task automatic predict_sample(logic signed [DATA_W-1:0] smp);
    int        nl;
    int        nm;
    int        nt;
    int        r;
    int        cnt;
    int        i;
    out_item_t o;
    nl = clip(int'(up_reg), UP_LIM);
    nm = clip(int'(down_reg), DOWN_LIM);
    nt = clip(int'(taps_reg), HIST_LEN);
    r = phase_off;
    cnt = 0;
    while (r <= 0 && cnt < MAX_OUT) begin
      o.sample_out = fir_point(-r, nl, nt);
      cnt++;
      r += nm;
      o.last = !(r <= 0 && cnt < MAX_OUT);
      due_outputs.push_back(o);
    end
    r -= nl;
    if (r < PH_MIN) r = PH_MIN;
    if (r > PH_MAX) r = PH_MAX;
    phase_off = r;
    for (i = 0; i < HIST_LEN - 1; i++) hist[i] = hist[i + 1];
    hist[HIST_LEN - 1] = smp;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    int        i;
    if (rst) begin
      for (i = 0; i < HIST_LEN; i++) hist[i] = '0;
      up_reg = UP_W'(1);
      down_reg = DOWN_W'(1);
      taps_reg = TAPS_W'(16);
      phase_off = 0;
      due_outputs.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_UP:   up_reg = cfg_data[UP_W-1:0];
          REG_DOWN: down_reg = cfg_data[DOWN_W-1:0];
          REG_TAPS: taps_reg = cfg_data[TAPS_W-1:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (due_outputs.size() == 0) begin
          fail_count++;
          $error("unexpected result: sample_out %0d last %0b", result.sample_out, result.last);
        end else begin
          want = due_outputs.pop_front();
          if (result.sample_out !== want.sample_out) begin
            fail_count++;
            $error("sample_out: expected %0d, got %0d", want.sample_out, result.sample_out);
          end
          if (result.last !== want.last) begin
            fail_count++;
            $error("last: expected %0b, got %0b", want.last, result.last);
          end
        end
      end
      if (feed.valid && feed.ready) begin
        if (feed.kind == KIND_COEF) coef_mem[feed.coef_index] = feed.coef_value;
        else predict_sample(feed.sample_in);
      end
    end
    outstanding <= due_outputs.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Resampler testbench top: clock, reset, stimulus, output stalls and verdict.
module tb_top;
  import prr_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 40;
  localparam int LONG_HOLD   = 1500;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 10;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   fail_count;
  int                   outstanding;
  int                   cycles = 0;
  int                   burst_left;
  bit                   feed_hot;
  bit                   hold_req;

  logic [DATA_W-1:0] corner_vals[6] = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000,
                                        32'hffff_ffff, 32'h0000_0001, 32'h4000_0000};

  prr_feed_if   feed_ch();
  prr_result_if result_ch();

  always #10 clk = ~clk;

  polyphase_rational_resampler_core i_dut (
    .clk,
    .rst,
    .feed      (feed_ch),
    .result    (result_ch),
    .cfg_wr_en,
    .cfg_index,
    .cfg_data
  );

  prr_output_checker i_checker (
    .clk,
    .rst,
    .feed        (feed_ch),
    .result      (result_ch),
    .cfg_wr_en,
    .cfg_index,
    .cfg_data,
    .fail_count,
    .outstanding
  );

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2, 3: return DATA_W'(int'($urandom_range(0, 2000)) - 1000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_factor(int hi);
    if ($urandom_range(0, 3) == 0) return CFG_W'($urandom_range(0, 31));
    return CFG_W'($urandom_range(1, hi));
  endfunction

  // One request; valid stays up inside a burst, drops for a random gap after it.
  task automatic send_req(input logic k, input logic [COEF_AW-1:0] ix,
                          input logic [DATA_W-1:0] cv, input logic [DATA_W-1:0] sv);
    feed_ch.valid <= 1'b1;
    feed_ch.kind <= k;
    feed_ch.coef_index <= ix;
    feed_ch.coef_value <= cv;
    feed_ch.sample_in <= sv;
    feed_hot = 1'b1;
    do @(posedge clk); while (!feed_ch.ready);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      feed_ch.valid <= 1'b0;
      feed_hot = 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  task automatic settle();
    if (feed_hot) begin
      feed_ch.valid <= 1'b0;
      feed_hot = 1'b0;
    end
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_factors(input logic [CFG_W-1:0] u, d, t);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_UP;
    cfg_data <= u;
    @(posedge clk);
    cfg_index <= REG_DOWN;
    cfg_data <= d;
    @(posedge clk);
    cfg_index <= REG_TAPS;
    cfg_data <= t;
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_data <= CFG_W'($urandom());
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] u, d, t, input int n, input bit with_loads);
    set_factors(u, d, t);
    repeat (n) begin
      if (with_loads && $urandom_range(0, 6) == 0)
        send_req(KIND_COEF, COEF_AW'($urandom()), pick_word(), $urandom());
      else
        send_req(KIND_SAMPLE, COEF_AW'($urandom()), $urandom(), pick_word());
    end
  endtask

  initial begin
    int i;
    int p;
    rst <= 1'b1;
    feed_ch.valid <= 1'b0;
    feed_ch.kind <= KIND_COEF;
    feed_ch.coef_index <= '0;
    feed_ch.coef_value <= '0;
    feed_ch.sample_in <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_UP;
    cfg_data <= '0;
    feed_hot = 1'b0;
    hold_req = 1'b0;
    burst_left = 4;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // whole table loaded up front so no phase ever reads an unwritten word
    for (i = 0; i < COEF_DEPTH; i++)
      send_req(KIND_COEF, COEF_AW'(i), pick_word(), $urandom());

    // reset factors, extreme coefficients and samples
    send_req(KIND_COEF, 7'd0, 32'h8000_0000, 32'h0000_0000);
    send_req(KIND_COEF, 7'd127, 32'h7fff_ffff, 32'hffff_ffff);
    foreach (corner_vals[i])
      send_req(KIND_SAMPLE, 7'h7f, 32'hffff_ffff, corner_vals[i]);

    settle();
    run_phase(5'd8, 5'd1, 5'd16, 3, 1'b0);
    settle();
    run_phase(5'd1, 5'd16, 5'd1, 4, 1'b0);
    settle();
    run_phase(5'd15, 5'd0, 5'd0, 2, 1'b0);
    settle();
    run_phase(5'd8, 5'd3, 5'd16, 3, 1'b0);
    settle();
    run_phase(5'd2, 5'd3, 5'd4, 3, 1'b0);

    for (p = 0; p < RAND_PHASES; p++) begin
      settle();
      if (p == 3) begin
        hold_req = 1'b1;
        run_phase(5'd8, 5'd2, 5'd16, PHASE_ITEMS, 1'b1);
      end else if (p == 6) begin
        run_phase(5'd5, 5'd31, 5'd31, PHASE_ITEMS, 1'b1);
      end else begin
        run_phase(pick_factor(8), pick_factor(16), pick_factor(16), PHASE_ITEMS, 1'b1);
      end
    end

    settle();
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // Output side: stall patterns of varying length, plus one long hold on request.
  initial begin
    int mode;
    int span;
    int i;
    result_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 200);
      for (i = 0; i < span; i++) begin
        if (hold_req) begin
          hold_req = 1'b0;
          result_ch.ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end
        case (mode)
          0: result_ch.ready <= 1'b1;
          1: result_ch.ready <= 1'($urandom_range(0, 1));
          2: result_ch.ready <= ($urandom_range(0, 3) == 0);
          default: result_ch.ready <= i[2];
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
